[hdl/mexp_pkg.sv]
// Shared constants and types for the modular exponentiation engine.
`timescale 1ns / 1ps
package mexp_pkg;
  localparam int WORD_BITS = 32;
  localparam int CNT_BITS  = $clog2(WORD_BITS);
  localparam int CFG_IDX_BITS = 1;

  localparam logic [CFG_IDX_BITS-1:0] CFG_EXPONENT = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_MODULUS  = 1'b1;

  typedef logic [WORD_BITS-1:0] word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_SQUARE,
    ST_MULT,
    ST_NEXT,
    ST_DONE
  } state_t;

  // Control of the cell row for one modular multiply.
  typedef struct packed {
    logic clr;     // clear the accumulator before a multiply
    logic step;    // perform one double-and-add step
    logic add_en;  // multiplier bit of this step
  } row_ctl_t;
endpackage

[hdl/mexp_if.sv]
// Request channel interfaces for base words and result words.
`timescale 1ns / 1ps
interface mexp_in_if;
  logic                  valid;
  logic                  ready;
  mexp_pkg::word_t       base_value;
  modport source (output valid, output base_value, input ready);
  modport sink   (input valid, input base_value, output ready);
endinterface

interface mexp_out_if;
  logic                  valid;
  logic                  ready;
  mexp_pkg::word_t       power_result;
  modport source (output valid, output power_result, input ready);
  modport sink   (input valid, input power_result, output ready);
endinterface

[hdl/mexp_cell.sv]
// One bit slice of the modular double-and-add accumulator.
`timescale 1ns / 1ps
module mexp_cell (
  input  logic clk,
  input  logic shift_in,
  input  logic m_bit,
  input  logic a_bit,
  input  mexp_pkg::row_ctl_t ctl,
  input  logic sel1,
  input  logic sel2,
  input  logic c1_in,
  input  logic c2_in,
  input  logic c3_in,
  output logic c1_out,
  output logic c2_out,
  output logic c3_out,
  output logic acc_bit
);
  logic acc_r, acc_nxt;
  logic d, nm, s1, x, ab, y, z;

  always_comb begin
    d  = shift_in;
    nm = ~m_bit;
    // Doubled value minus the modulus.
    s1     = d ^ nm ^ c1_in;
    c1_out = (d & nm) | (c1_in & (d ^ nm));
    x      = sel1 ? s1 : d;
    // Add the multiplicand when the multiplier bit is set.
    ab     = a_bit & ctl.add_en;
    y      = x ^ ab ^ c2_in;
    c2_out = (x & ab) | (c2_in & (x ^ ab));
    z      = y ^ nm ^ c3_in;
    c3_out = (y & nm) | (c3_in & (y ^ nm));
    acc_nxt = acc_r;
    if (ctl.clr) begin
      acc_nxt = 1'b0;
    end else if (ctl.step) begin
      acc_nxt = sel2 ? z : y;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

  assign acc_bit = acc_r;
endmodule

[hdl/mexp_row.sv]
// Row of bit cells forming a serial modular multiplier.
`timescale 1ns / 1ps
module mexp_row (
  input  logic               clk,
  input  mexp_pkg::row_ctl_t ctl,
  input  mexp_pkg::word_t    modulus,
  input  mexp_pkg::word_t    multiplicand,
  output mexp_pkg::word_t    acc
);
  localparam int W = mexp_pkg::WORD_BITS;

  logic [W:0]   c1, c2, c3;
  logic [W-1:0] shift;
  logic         m_nz, sel1, sel2;

  assign c1[0] = 1'b1;
  assign c2[0] = 1'b0;
  assign c3[0] = 1'b1;
  assign shift = {acc[W-2:0], 1'b0};
  assign m_nz  = |modulus;
  // A zero modulus disables reduction, so the products wrap at the word width.
  assign sel1  = m_nz & (acc[W-1] | c1[W]);
  assign sel2  = m_nz & (c2[W] | c3[W]);

  for (genvar i = 0; i < W; i++) begin : g_cell
    mexp_cell u_cell (
      .clk     (clk),
      .shift_in(shift[i]),
      .m_bit   (modulus[i]),
      .a_bit   (multiplicand[i]),
      .ctl     (ctl),
      .sel1    (sel1),
      .sel2    (sel2),
      .c1_in   (c1[i]),
      .c2_in   (c2[i]),
      .c3_in   (c3[i]),
      .c1_out  (c1[i+1]),
      .c2_out  (c2[i+1]),
      .c3_out  (c3[i+1]),
      .acc_bit (acc[i])
    );
  end
endmodule

[hdl/modular_exponentiation.sv]
// Top level: sequencer for square-and-multiply over a row of multiplier cells.
// Each modular multiply steps through all multiplier bits, then ST_NEXT loads the next operands.
// The base is reduced first, then squared for every exponent bit and multiplied in for every set bit;
// a zero exponent skips the multiplies and gives a result of one.
// One request is in flight at a time; the next is taken the cycle after the result is loaded.
// Synchronous active-low reset sets the exponent to 0, the modulus to 1 and empties the output.
`timescale 1ns / 1ps
module modular_exponentiation (
  input  logic clk,
  input  logic rst_n,
  input  logic cfg_we,
  input  logic [mexp_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  mexp_pkg::word_t cfg_data,
  mexp_in_if.sink    in_ch,
  mexp_out_if.source out_ch
);
  localparam int CB = mexp_pkg::CNT_BITS;
  localparam int W  = mexp_pkg::WORD_BITS;

  mexp_pkg::word_t exp_r, mod_r, base_r, res_r, a_r, mult_r, out_r;
  mexp_pkg::word_t a_nxt, mult_nxt, base_nxt, res_nxt, out_nxt;
  mexp_pkg::word_t acc, unit;
  logic [CB-1:0] step_r, step_nxt, idx_r, idx_nxt;
  logic out_valid_r, out_valid_nxt;
  mexp_pkg::state_t state_r, state_nxt, last_op_r, last_op_nxt;
  mexp_pkg::row_ctl_t ctl;
  logic in_acc, last_step;

  assign in_ch.ready  = (state_r == mexp_pkg::ST_IDLE);
  assign in_acc       = in_ch.valid & in_ch.ready;
  assign out_ch.valid = out_valid_r;
  assign out_ch.power_result = out_r;
  assign last_step    = (step_r == CB'(W - 1));
  // A unit modulus makes every power with a nonzero exponent zero.
  assign unit = (mod_r == mexp_pkg::word_t'(1)) ? '0 : mexp_pkg::word_t'(1);

  mexp_row u_row (
    .clk         (clk),
    .ctl         (ctl),
    .modulus     (mod_r),
    .multiplicand(a_r),
    .acc         (acc)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_r       <= '0;
      mod_r       <= mexp_pkg::word_t'(1);
      state_r     <= mexp_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we && cfg_index == mexp_pkg::CFG_EXPONENT) begin
        exp_r <= cfg_data;
      end
      if (cfg_we && cfg_index == mexp_pkg::CFG_MODULUS) begin
        mod_r <= cfg_data;
      end
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    step_r    <= step_nxt;
    idx_r     <= idx_nxt;
    a_r       <= a_nxt;
    mult_r    <= mult_nxt;
    base_r    <= base_nxt;
    res_r     <= res_nxt;
    out_r     <= out_nxt;
    last_op_r <= last_op_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    last_op_nxt   = last_op_r;
    out_valid_nxt = out_valid_r & ~out_ch.ready;
    step_nxt      = step_r;
    idx_nxt       = idx_r;
    a_nxt         = a_r;
    mult_nxt      = mult_r;
    base_nxt      = base_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    ctl.clr       = 1'b0;
    ctl.step      = 1'b0;
    ctl.add_en    = mult_r[W-1];
    case (state_r)
      mexp_pkg::ST_IDLE: begin
        if (in_acc) begin
          step_nxt = '0;
          idx_nxt  = CB'(W - 1);
          if (exp_r == '0) begin
            res_nxt   = mexp_pkg::word_t'(1);
            state_nxt = mexp_pkg::ST_DONE;
          end else begin
            // Reduce the base by multiplying it by one.
            ctl.clr   = 1'b1;
            a_nxt     = mexp_pkg::word_t'(1);
            mult_nxt  = in_ch.base_value;
            state_nxt = mexp_pkg::ST_REDUCE;
          end
        end
      end
      mexp_pkg::ST_REDUCE, mexp_pkg::ST_SQUARE, mexp_pkg::ST_MULT: begin
        ctl.step = 1'b1;
        mult_nxt = {mult_r[W-2:0], 1'b0};
        step_nxt = step_r + 1'b1;
        if (last_step) begin
          step_nxt    = '0;
          last_op_nxt = state_r;
          state_nxt   = mexp_pkg::ST_NEXT;
        end
      end
      mexp_pkg::ST_NEXT: begin
        // The accumulator now holds the finished product; choose the next multiply.
        case (last_op_r)
          mexp_pkg::ST_REDUCE: begin
            base_nxt  = acc;
            a_nxt     = unit;
            mult_nxt  = unit;
            ctl.clr   = 1'b1;
            state_nxt = mexp_pkg::ST_SQUARE;
          end
          mexp_pkg::ST_SQUARE: begin
            if (exp_r[idx_r]) begin
              a_nxt     = base_r;
              mult_nxt  = acc;
              ctl.clr   = 1'b1;
              state_nxt = mexp_pkg::ST_MULT;
            end else if (idx_r == '0) begin
              res_nxt   = acc;
              state_nxt = mexp_pkg::ST_DONE;
            end else begin
              idx_nxt   = idx_r - 1'b1;
              a_nxt     = acc;
              mult_nxt  = acc;
              ctl.clr   = 1'b1;
              state_nxt = mexp_pkg::ST_SQUARE;
            end
          end
          mexp_pkg::ST_MULT: begin
            if (idx_r == '0) begin
              res_nxt   = acc;
              state_nxt = mexp_pkg::ST_DONE;
            end else begin
              idx_nxt   = idx_r - 1'b1;
              a_nxt     = acc;
              mult_nxt  = acc;
              ctl.clr   = 1'b1;
              state_nxt = mexp_pkg::ST_SQUARE;
            end
          end
          default: state_nxt = mexp_pkg::ST_IDLE;
        endcase
      end
      mexp_pkg::ST_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_nxt       = res_r;
          state_nxt     = mexp_pkg::ST_IDLE;
        end
      end
      default: state_nxt = mexp_pkg::ST_IDLE;
    endcase
  end

`ifndef SYNTHESIS
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.power_result));
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_ch.valid);
  a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != mexp_pkg::ST_IDLE) |-> !in_ch.ready);
`endif
endmodule

[test/modular_exponentiation_tb.sv]
// Self-checking testbench for the modular exponentiation engine.
`timescale 1ns / 1ps
module modular_exponentiation_tb;
  localparam int CYCLE_LIMIT = 4_000_000;
  localparam int WB = mexp_pkg::WORD_BITS;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [mexp_pkg::CFG_IDX_BITS-1:0] cfg_index = mexp_pkg::CFG_EXPONENT;
  mexp_pkg::word_t cfg_data = '0;

  mexp_in_if  in_ch ();
  mexp_out_if out_ch ();

  modular_exponentiation u_dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  always #5 clk = ~clk;

  mexp_pkg::word_t exp_key;
  mexp_pkg::word_t mod_key;
  mexp_pkg::word_t expected_powers[$];
  int mismatches = 0;
  int cycles = 0;
  int out_wait = 0;
  bit stall_free = 1'b0;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.base_value = '0;
    out_ch.ready = 1'b0;
  end

  // Modular product, wrapping to the word width when the modulus is zero.
  function automatic mexp_pkg::word_t mul_word(mexp_pkg::word_t a, mexp_pkg::word_t b,
                                               mexp_pkg::word_t m);
    logic [2*WB-1:0] p;
    p = a * b;
    if (m == 0) return p[WB-1:0];
    return mexp_pkg::word_t'(p % m);
  endfunction

  function automatic mexp_pkg::word_t power_mod(mexp_pkg::word_t base, mexp_pkg::word_t e,
                                                mexp_pkg::word_t m);
    mexp_pkg::word_t acc;
    mexp_pkg::word_t b;
    if (e == 0) return mexp_pkg::word_t'(1);
    b = (m != 0) ? base % m : base;
    acc = (m == 1) ? mexp_pkg::word_t'(0) : mexp_pkg::word_t'(1);
    for (int i = WB - 1; i >= 0; i--) begin
      acc = mul_word(acc, acc, m);
      if (e[i]) acc = mul_word(acc, b, m);
    end
    return acc;
  endfunction

  task automatic write_key(logic [mexp_pkg::CFG_IDX_BITS-1:0] idx, mexp_pkg::word_t val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == mexp_pkg::CFG_EXPONENT) exp_key = val;
    else mod_key = val;
  endtask

  task automatic set_keys(mexp_pkg::word_t e, mexp_pkg::word_t m);
    while (expected_powers.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    write_key(mexp_pkg::CFG_EXPONENT, e);
    write_key(mexp_pkg::CFG_MODULUS, m);
  endtask

  task automatic send_base(mexp_pkg::word_t base);
    int gap;
    gap = stall_free ? 0 : $urandom_range(0, 11);
    // Leave the edge at which the previous request was taken before driving again.
    @(posedge clk);
    repeat (gap) @(posedge clk);
    in_ch.valid <= 1'b1;
    in_ch.base_value <= base;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    expected_powers.push_back(power_mod(base, exp_key, mod_key));
    in_ch.valid <= 1'b0;
  endtask

  // The receiver waits a drawn number of cycles for each result, except when stall-free.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (out_ch.valid && out_ch.ready) begin
      if (expected_powers.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result %h", out_ch.power_result);
      end else begin
        mexp_pkg::word_t want;
        want = expected_powers.pop_front();
        if (out_ch.power_result !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("power_result mismatch: expected %h, got %h",
                     want, out_ch.power_result);
        end
      end
      out_wait = stall_free ? 0 : $urandom_range(0, 11);
    end else if (out_ch.valid && out_wait > 0) begin
      out_wait--;
    end
    out_ch.ready <= (out_wait == 0);
    if (cycles >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic test_reset_keys();
    exp_key = 0;
    mod_key = 1;
    send_base(32'h0000_0041);
    send_base(32'hFFFF_FFFF);
  endtask

  task automatic test_directed();
    set_keys(32'd0, 32'd0);
    send_base(32'd0);
    set_keys(32'd5, 32'd1);
    send_base(32'd7);
    send_base(32'hFFFF_FFFF);
    set_keys(32'd17, 32'd3233);
    send_base(32'd65);
    send_base(32'd3233);
    send_base(32'd3232);
    send_base(32'd0);
    set_keys(32'd2753, 32'd3233);
    send_base(32'd2790);
    set_keys(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_base(32'hFFFF_FFFE);
    send_base(32'hFFFF_FFFF);
    send_base(32'd2);
    set_keys(32'hFFFF_FFFF, 32'd0);
    send_base(32'hFFFF_FFFF);
    send_base(32'd3);
    set_keys(32'h8000_0000, 32'hFFFF_FFFB);
    send_base(32'h1234_5678);
  endtask

  task automatic test_random();
    for (int phase = 0; phase < 14; phase++) begin
      mexp_pkg::word_t e;
      mexp_pkg::word_t m;
      case (phase % 4)
        0: m = $urandom();
        1: m = $urandom_range(2, 70000);
        2: m = (phase == 6) ? 32'd0 : 32'd1 << $urandom_range(0, 31);
        default: m = $urandom() | 32'h8000_0000;
      endcase
      e = (phase == 9) ? 32'd0 : ((phase % 3 == 0) ? $urandom() : $urandom_range(1, 65537));
      set_keys(e, m);
      stall_free = (phase % 5 == 4);
      for (int k = 0; k < 20; k++)
        send_base($urandom_range(0, 3) == 0 ? $urandom_range(0, 255) : $urandom());
      stall_free = 1'b0;
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_keys();
    test_directed();
    test_random();
    while (expected_powers.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
